// ===== hw/rtl/ftprm_pkg.sv =====
// Shared types, constants and helpers for the five-tuple prefix rule matcher.
package ftprm_pkg;

   localparam int RULES_DEFAULT = 16;
   localparam int MAX_SLOTS     = 16;
   localparam int ADDR_W        = 32;
   localparam int PORT_W        = 16;
   localparam int PREFIX_W      = 6;
   localparam int HDR_W         = 4;
   localparam int PROTO_W       = 8;
   localparam int INDEX_W       = 4;
   localparam int KIND_W        = 2;

   localparam logic [PROTO_W-1:0]  TCP_PROTO     = 8'd6;
   localparam logic [HDR_W-1:0]    MIN_HDR_WORDS = 4'd5;
   localparam logic [PREFIX_W-1:0] FULL_PREFIX   = 6'd32;

   localparam logic [KIND_W-1:0] KIND_WRITTEN = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MATCH   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NOMATCH = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SKIPPED = 2'd3;

   typedef struct packed {
      logic [ADDR_W-1:0] src_addr;
      logic [ADDR_W-1:0] smask;
      logic [PORT_W-1:0] sport;
      logic [ADDR_W-1:0] dst_addr;
      logic [ADDR_W-1:0] dmask;
      logic [PORT_W-1:0] dport;
   } rule_type;

   typedef struct packed {
      logic              load_rule;
      logic              load_pkt;
      logic              issue;
      logic              pop;
      logic              out_load;
      logic [KIND_W-1:0] out_kind;
   } ftprm_cmd_type;

   typedef struct packed {
      logic is_packet;
      logic hdr_ok;
      logic scan_done;
      logic hits_any;
      logic hit_single;
      logic out_free;
   } ftprm_sts_type;

   // prefix 0 matches anything, anything above 32 is an exact compare
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] len);
      logic [PREFIX_W-1:0] n;
      n = (len > FULL_PREFIX) ? FULL_PREFIX : len;
      return ~({ADDR_W{1'b1}} >> n);
   endfunction

endpackage

// ===== hw/rtl/five_tuple_prefix_rule_matcher_unit.sv =====
// Top level of the five-tuple prefix rule matcher.
// Rule write or uninspected packet: one item, result registered in the cycle after accept.
// Inspected packet: one rule read and compared per cycle over min(RULES,16) rules,
// then a drain state, then one result per cycle while the output is not stalled.
// The next item is accepted only after the packet's last result has been registered.
// Reset clears state, valid bits and the result valid flag; rule contents are undefined until written.
module five_tuple_prefix_rule_matcher_unit import ftprm_pkg::*; #(
   parameter int RULES = RULES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // rule_index, rule_enable, src_addr, src_prefix, sport, dst_addr, dst_prefix,
   // dport, ip_header_words, protocol, tcp_header_words, zero pad
   input  logic [135:0] req_tdata,
   input  logic         req_tuser,  // mode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,  // match_index, zero pad
   output logic [1:0]   rsp_tuser,  // result_kind
   output logic         rsp_tlast   // last
);

   ftprm_cmd_type      cmd;
   ftprm_sts_type      sts;
   logic [INDEX_W-1:0] match_index;

   ftprm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ftprm_dpath #(
      .RULES (RULES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .mode             (req_tuser),
      .rule_index       (req_tdata[3:0]),
      .rule_enable      (req_tdata[4]),
      .src_addr         (req_tdata[36:5]),
      .src_prefix       (req_tdata[42:37]),
      .sport            (req_tdata[58:43]),
      .dst_addr         (req_tdata[90:59]),
      .dst_prefix       (req_tdata[96:91]),
      .dport            (req_tdata[112:97]),
      .ip_header_words  (req_tdata[116:113]),
      .protocol         (req_tdata[124:117]),
      .tcp_header_words (req_tdata[128:125]),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .result_kind      (rsp_tuser),
      .match_index      (match_index),
      .last             (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, match_index};

endmodule

// ===== hw/rtl/ftprm_dpath.sv =====
// Datapath: rule memory, valid bits, packet registers, compare, hit vector, result register.
module ftprm_dpath import ftprm_pkg::*; #(
   parameter int RULES = RULES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  ftprm_cmd_type       cmd,
   output ftprm_sts_type       sts,
   input  logic                mode,
   input  logic [INDEX_W-1:0]  rule_index,
   input  logic                rule_enable,
   input  logic [ADDR_W-1:0]   src_addr,
   input  logic [PREFIX_W-1:0] src_prefix,
   input  logic [PORT_W-1:0]   sport,
   input  logic [ADDR_W-1:0]   dst_addr,
   input  logic [PREFIX_W-1:0] dst_prefix,
   input  logic [PORT_W-1:0]   dport,
   input  logic [HDR_W-1:0]    ip_header_words,
   input  logic [PROTO_W-1:0]  protocol,
   input  logic [HDR_W-1:0]    tcp_header_words,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [KIND_W-1:0]   result_kind,
   output logic [INDEX_W-1:0]  match_index,
   output logic                last
);

   localparam int SLOTS = (RULES < MAX_SLOTS) ? RULES : MAX_SLOTS;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   rule_type             rule_mem [SLOTS];
   rule_type             rd_rule_ff;
   logic                 rd_valid_ff;
   logic [SLOTS-1:0]     valid_ff;
   logic [IDX_W-1:0]     ptr_ff;
   logic [IDX_W-1:0]     cmp_idx_ff;
   logic                 cmp_en_ff;
   logic [SLOTS-1:0]     hits_ff;
   logic [SLOTS-1:0]     hits_in;
   logic [ADDR_W-1:0]    pkt_src_addr_ff;
   logic [PORT_W-1:0]    pkt_sport_ff;
   logic [ADDR_W-1:0]    pkt_dst_addr_ff;
   logic [PORT_W-1:0]    pkt_dport_ff;
   logic                 rsp_valid_ff;
   logic [KIND_W-1:0]    kind_ff;
   logic [INDEX_W-1:0]   index_ff;
   logic                 last_ff;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   rule_type             wr_rule;
   logic                 match;
   logic [IDX_W-1:0]     low_idx;
   logic [SLOTS-1:0]     hits_rest;

   assign wr_en   = cmd.load_rule && ({1'b0, rule_index} < (INDEX_W + 1)'(SLOTS));
   assign wr_addr = rule_index[IDX_W-1:0];

   always_comb begin
      wr_rule.src_addr = src_addr;
      wr_rule.smask    = prefix_mask(src_prefix);
      wr_rule.sport    = sport;
      wr_rule.dst_addr = dst_addr;
      wr_rule.dmask    = prefix_mask(dst_prefix);
      wr_rule.dport    = dport;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rule_mem[wr_addr] <= wr_rule;
      end
      if (cmd.issue) begin
         rd_rule_ff  <= rule_mem[ptr_ff];
         rd_valid_ff <= valid_ff[ptr_ff];
         cmp_idx_ff  <= ptr_ff;
      end
      if (cmd.load_pkt) begin
         pkt_src_addr_ff <= src_addr;
         pkt_sport_ff    <= sport;
         pkt_dst_addr_ff <= dst_addr;
         pkt_dport_ff    <= dport;
      end
      if (cmd.out_load) begin
         kind_ff  <= cmd.out_kind;
         index_ff <= (cmd.out_kind == KIND_MATCH) ? INDEX_W'(low_idx) : '0;
         last_ff  <= (cmd.out_kind == KIND_MATCH) ? sts.hit_single : 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         ptr_ff       <= '0;
         cmp_en_ff    <= 1'b0;
         hits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= rule_enable;
         end
         if (cmd.load_pkt) begin
            ptr_ff <= '0;
         end else if (cmd.issue) begin
            ptr_ff <= ptr_ff + IDX_W'(1);
         end
         cmp_en_ff <= cmd.issue;
         hits_ff   <= hits_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign match = rd_valid_ff
      && (((pkt_src_addr_ff ^ rd_rule_ff.src_addr) & rd_rule_ff.smask) == '0)
      && (pkt_sport_ff == rd_rule_ff.sport)
      && (((pkt_dst_addr_ff ^ rd_rule_ff.dst_addr) & rd_rule_ff.dmask) == '0)
      && (pkt_dport_ff == rd_rule_ff.dport);

   assign hits_rest = hits_ff & (hits_ff - SLOTS'(1));

   always_comb begin
      hits_in = hits_ff;
      if (cmd.load_pkt) begin
         hits_in = '0;
      end else if (cmp_en_ff) begin
         hits_in[cmp_idx_ff] = match;
      end else if (cmd.pop) begin
         hits_in = hits_rest;
      end
   end

   always_comb begin
      low_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (hits_ff[i]) begin
            low_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      sts.is_packet  = mode;
      sts.hdr_ok     = (ip_header_words >= MIN_HDR_WORDS) && (protocol == TCP_PROTO)
                       && (tcp_header_words >= MIN_HDR_WORDS);
      sts.scan_done  = (ptr_ff == IDX_W'(SLOTS - 1));
      sts.hits_any   = (hits_ff != '0);
      sts.hit_single = (hits_rest == '0);
      sts.out_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign result_kind = kind_ff;
   assign match_index = index_ff;
   assign last        = last_ff;

   a_pop_needs_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (hits_ff != '0))
      else $error("pop with empty hit vector");

   a_pkt_clears_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.load_pkt |=> ((hits_ff == '0) && (ptr_ff == '0)))
      else $error("scan state not cleared on packet load");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");

endmodule

// ===== hw/rtl/ftprm_ctrl.sv =====
// Controller: sequences rule writes, packet scan and result emission.
module ftprm_ctrl import ftprm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  ftprm_sts_type sts,
   output ftprm_cmd_type cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE) && sts.out_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.out_kind = KIND_WRITTEN;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!sts.is_packet) begin
                  cmd.load_rule = 1'b1;
                  cmd.out_load  = 1'b1;
                  cmd.out_kind  = KIND_WRITTEN;
               end else if (!sts.hdr_ok) begin
                  cmd.out_load  = 1'b1;
                  cmd.out_kind  = KIND_SKIPPED;
               end else begin
                  cmd.load_pkt  = 1'b1;
                  state_in      = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.issue = 1'b1;
            if (sts.scan_done) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               if (!sts.hits_any) begin
                  cmd.out_kind = KIND_NOMATCH;
                  state_in     = S_IDLE;
               end else begin
                  cmd.out_kind = KIND_MATCH;
                  cmd.pop      = 1'b1;
                  if (sts.hit_single) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("input taken while busy");

   a_drain_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |=> (state_ff == S_EMIT))
      else $error("drain not followed by emit");

   a_final_to_idle: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_EMIT) && cmd.out_load && (!sts.hits_any || sts.hit_single))
      |=> (state_ff == S_IDLE))
      else $error("final result did not end the packet");

endmodule

// ===== verif/five_tuple_prefix_rule_matcher_unit_tb.sv =====
// Self-checking testbench for the five-tuple rule matcher: directed table, then random traffic.
`timescale 1ns / 100ps

module five_tuple_prefix_rule_matcher_unit_tb;
   import ftprm_pkg::*;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_PACKET = 1'b1;
   localparam int   DIR_ROWS    = 21;
   localparam int   RAND_PER_PHASE = 104;

   typedef struct {
      logic                mode;
      logic [INDEX_W-1:0]  rule_index;
      logic                rule_enable;
      logic [ADDR_W-1:0]   src_addr;
      logic [PREFIX_W-1:0] src_prefix;
      logic [PORT_W-1:0]   sport;
      logic [ADDR_W-1:0]   dst_addr;
      logic [PREFIX_W-1:0] dst_prefix;
      logic [PORT_W-1:0]   dport;
      logic [HDR_W-1:0]    ip_words;
      logic [PROTO_W-1:0]  protocol;
      logic [HDR_W-1:0]    tcp_words;
   } req_item_type;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [INDEX_W-1:0] match_idx;
      logic               last;
   } result_type;

   typedef struct {
      req_item_type      item;
      bit                typed;
      logic [KIND_W-1:0] kind;
   } dir_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;

   // rule table as the predictor sees it
   logic [ADDR_W-1:0]   tbl_src_addr [MAX_SLOTS];
   logic [PREFIX_W-1:0] tbl_src_len  [MAX_SLOTS];
   logic [PORT_W-1:0]   tbl_sport    [MAX_SLOTS];
   logic [ADDR_W-1:0]   tbl_dst_addr [MAX_SLOTS];
   logic [PREFIX_W-1:0] tbl_dst_len  [MAX_SLOTS];
   logic [PORT_W-1:0]   tbl_dport    [MAX_SLOTS];
   bit                  tbl_valid    [MAX_SLOTS];

   result_type  pending_results[$];
   dir_row_type dir_table [DIR_ROWS];
   int          mismatches = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;

   five_tuple_prefix_rule_matcher_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [ADDR_W-1:0] net_mask(input logic [PREFIX_W-1:0] len);
      int n;
      n = (len > ADDR_W) ? ADDR_W : int'(len);
      if (n == 0) return '0;
      return {ADDR_W{1'b1}} << (ADDR_W - n);
   endfunction

   function automatic void classify(input req_item_type it, output result_type res[$]);
      res = {};
      if (it.mode == MODE_LOAD) begin
         tbl_src_addr[it.rule_index] = it.src_addr;
         tbl_src_len[it.rule_index]  = it.src_prefix;
         tbl_sport[it.rule_index]    = it.sport;
         tbl_dst_addr[it.rule_index] = it.dst_addr;
         tbl_dst_len[it.rule_index]  = it.dst_prefix;
         tbl_dport[it.rule_index]    = it.dport;
         tbl_valid[it.rule_index]    = it.rule_enable;
         res.push_back('{KIND_WRITTEN, '0, 1'b1});
         return;
      end
      if (it.ip_words < MIN_HDR_WORDS || it.protocol != TCP_PROTO ||
          it.tcp_words < MIN_HDR_WORDS) begin
         res.push_back('{KIND_SKIPPED, '0, 1'b1});
         return;
      end
      for (int i = 0; i < MAX_SLOTS; i++) begin
         if (tbl_valid[i] &&
             ((it.src_addr ^ tbl_src_addr[i]) & net_mask(tbl_src_len[i])) == '0 &&
             it.sport == tbl_sport[i] &&
             ((it.dst_addr ^ tbl_dst_addr[i]) & net_mask(tbl_dst_len[i])) == '0 &&
             it.dport == tbl_dport[i])
            res.push_back('{KIND_MATCH, INDEX_W'(i), 1'b0});
      end
      if (res.size() == 0)
         res.push_back('{KIND_NOMATCH, '0, 1'b1});
      else
         res[res.size()-1].last = 1'b1;
   endfunction

   function automatic req_item_type pkt(input logic [ADDR_W-1:0] sa, input logic [PORT_W-1:0] sp,
                                        input logic [ADDR_W-1:0] da, input logic [PORT_W-1:0] dp,
                                        input logic [HDR_W-1:0] ihl, input logic [PROTO_W-1:0] pr,
                                        input logic [HDR_W-1:0] thl);
      return '{MODE_PACKET, '0, 1'b0, sa, '0, sp, da, '0, dp, ihl, pr, thl};
   endfunction

   function automatic req_item_type rule(input logic [INDEX_W-1:0] idx, input logic en,
                                         input logic [ADDR_W-1:0] sa,
                                         input logic [PREFIX_W-1:0] sl,
                                         input logic [PORT_W-1:0] sp,
                                         input logic [ADDR_W-1:0] da,
                                         input logic [PREFIX_W-1:0] dl,
                                         input logic [PORT_W-1:0] dp);
      return '{MODE_LOAD, idx, en, sa, sl, sp, da, dl, dp, '0, '0, '0};
   endfunction

   function automatic logic [PREFIX_W-1:0] pick_prefix();
      int r;
      r = $urandom_range(9);
      if (r < 2) return '0;
      if (r == 2) return PREFIX_W'(ADDR_W);
      if (r == 3) return PREFIX_W'($urandom_range(63, 33));
      return PREFIX_W'($urandom_range(31, 1));
   endfunction

   function automatic req_item_type random_item();
      req_item_type it;
      int pick, slot;
      it = '{MODE_PACKET, INDEX_W'($urandom), 1'($urandom), $urandom, PREFIX_W'($urandom),
             PORT_W'($urandom), $urandom, PREFIX_W'($urandom), PORT_W'($urandom),
             HDR_W'($urandom), PROTO_W'($urandom), HDR_W'($urandom)};
      pick = $urandom_range(99);
      if (pick < 25) begin
         it.mode        = MODE_LOAD;
         it.rule_enable = ($urandom_range(9) != 0);
         if ($urandom_range(1)) it.src_addr = 32'hC0A8_0000 | $urandom_range(65535);
         if ($urandom_range(1)) it.dst_addr = 32'h0A00_0000 | $urandom_range(65535);
         it.src_prefix = pick_prefix();
         it.dst_prefix = pick_prefix();
         if ($urandom_range(9) < 6) begin
            it.sport = $urandom_range(1) ? 16'h0400 : 16'hFFFF;
            it.dport = $urandom_range(1) ? 16'd80 : 16'd443;
         end
      end else if (pick < 80) begin
         // aim at a stored rule, scrambling the bits its prefixes leave free
         slot = $urandom_range(MAX_SLOTS - 1);
         it.src_addr  = tbl_src_addr[slot] ^ ($urandom & ~net_mask(tbl_src_len[slot]));
         it.dst_addr  = tbl_dst_addr[slot] ^ ($urandom & ~net_mask(tbl_dst_len[slot]));
         it.sport     = tbl_sport[slot];
         it.dport     = tbl_dport[slot];
         if ($urandom_range(9) == 0) it.dport[$urandom_range(PORT_W - 1)] ^= 1'b1;
         it.ip_words  = HDR_W'($urandom_range(15, 5));
         it.protocol  = TCP_PROTO;
         it.tcp_words = HDR_W'($urandom_range(15, 5));
      end else if (pick < 90) begin
         it.protocol = TCP_PROTO;
      end
      return it;
   endfunction

   task automatic report_mismatch(input string field, input int got_v, input int want_v);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got_v, want_v);
      mismatches++;
   endtask

   task automatic send_item(input req_item_type it, input bit typed,
                            input logic [KIND_W-1:0] kind);
      result_type res[$];
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tuser  <= it.mode;
      req_tdata  <= {7'd0, it.tcp_words, it.protocol, it.ip_words, it.dport, it.dst_prefix,
                     it.dst_addr, it.sport, it.src_prefix, it.src_addr, it.rule_enable,
                     it.rule_index};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      classify(it, res);
      if (typed)
         pending_results.push_back('{kind, '0, 1'b1});
      else
         foreach (res[k]) pending_results.push_back(res[k]);
   endtask

   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected item, kind", int'(rsp_tuser), -1);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.kind)
               report_mismatch("result_kind", int'(rsp_tuser), int'(want.kind));
            if (rsp_tdata[INDEX_W-1:0] !== want.match_idx)
               report_mismatch("match_index", int'(rsp_tdata[INDEX_W-1:0]),
                               int'(want.match_idx));
            if (rsp_tlast !== want.last)
               report_mismatch("last", int'(rsp_tlast), int'(want.last));
         end
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin : stimulus
      foreach (tbl_valid[i]) begin
         tbl_valid[i]    = 1'b0;
         tbl_src_addr[i] = '0;
         tbl_src_len[i]  = '0;
         tbl_sport[i]    = '0;
         tbl_dst_addr[i] = '0;
         tbl_dst_len[i]  = '0;
         tbl_dport[i]    = '0;
      end
      dir_table = '{
         '{pkt(32'h0102_0304, 16'd1000, 32'h0506_0708, 16'd80, 4'd5, TCP_PROTO, 4'd5),
           1'b1, KIND_NOMATCH},
         '{pkt(32'h0102_0304, 16'd1000, 32'h0506_0708, 16'd80, 4'd4, TCP_PROTO, 4'd5),
           1'b1, KIND_SKIPPED},
         '{pkt(32'h0102_0304, 16'd1000, 32'h0506_0708, 16'd80, 4'd5, 8'd17, 4'd5),
           1'b1, KIND_SKIPPED},
         '{pkt(32'h0102_0304, 16'd1000, 32'h0506_0708, 16'd80, 4'd5, TCP_PROTO, 4'd4),
           1'b1, KIND_SKIPPED},
         '{pkt('0, '0, '0, '0, 4'd0, 8'd0, 4'd0), 1'b1, KIND_SKIPPED},
         '{pkt('1, '1, '1, '1, 4'd15, 8'd255, 4'd15), 1'b1, KIND_SKIPPED},
         '{rule(4'd0, 1'b1, '1, 6'd32, '1, '1, 6'd32, '1), 1'b1, KIND_WRITTEN},
         '{rule(4'd15, 1'b1, '0, 6'd0, '0, '0, 6'd0, '0), 1'b1, KIND_WRITTEN},
         '{pkt('1, '1, '1, '1, 4'd15, TCP_PROTO, 4'd15), 1'b0, KIND_WRITTEN},
         '{pkt('0, '0, '0, '0, 4'd5, TCP_PROTO, 4'd5), 1'b0, KIND_WRITTEN},
         '{pkt(32'h1234_5678, '0, 32'h9ABC_DEF0, '0, 4'd7, TCP_PROTO, 4'd9), 1'b0, KIND_WRITTEN},
         '{rule(4'd5, 1'b1, 32'h0A00_0001, 6'd63, 16'd1234, 32'hC0A8_0101, 6'd40, 16'd80),
           1'b1, KIND_WRITTEN},
         '{rule(4'd6, 1'b1, 32'h0AFF_FFFF, 6'd8, 16'd1234, 32'hC0A8_FFFF, 6'd16, 16'd80),
           1'b1, KIND_WRITTEN},
         '{pkt(32'h0A00_0001, 16'd1234, 32'hC0A8_0101, 16'd80, 4'd5, TCP_PROTO, 4'd5),
           1'b0, KIND_WRITTEN},
         '{pkt(32'h0A00_0000, 16'd1234, 32'hC0A8_0101, 16'd80, 4'd5, TCP_PROTO, 4'd5),
           1'b0, KIND_WRITTEN},
         '{pkt(32'h0A00_0001, 16'd1234, 32'hC0A8_0101, 16'd81, 4'd5, TCP_PROTO, 4'd5),
           1'b0, KIND_WRITTEN},
         '{rule(4'd15, 1'b0, '0, 6'd0, '0, '0, 6'd0, '0), 1'b1, KIND_WRITTEN},
         '{pkt('0, '0, '0, '0, 4'd5, TCP_PROTO, 4'd5), 1'b0, KIND_WRITTEN},
         '{rule(4'd3, 1'b1, 32'h8000_0000, 6'd1, 16'h8000, 32'h0000_0001, 6'd31, 16'd1),
           1'b1, KIND_WRITTEN},
         '{pkt('1, 16'h8000, '0, 16'd1, 4'd6, TCP_PROTO, 4'd8), 1'b0, KIND_WRITTEN},
         '{pkt(32'h7FFF_FFFF, 16'h8000, '0, 16'd1, 4'd5, TCP_PROTO, 4'd5), 1'b0, KIND_WRITTEN}
      };
      send_idle_pct = 6;
      stall_pct     = 53;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_table[r])
         send_item(dir_table[r].item, dir_table[r].typed, dir_table[r].kind);
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 53 : 0;
         stall_pct     = (ph == 0) ? 53 : (ph == 1) ? 6 : 0;
         repeat (RAND_PER_PHASE) send_item(random_item(), 1'b0, KIND_WRITTEN);
      end
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin : watchdog
      #(5_000_000);
      $display("FAIL");
      $finish;
   end

endmodule
